[rtl/mbe_pkg.sv]
// mbe_pkg: shared types, constants and palette helpers for the escape-time colouring block
// no dependencies; imported by every module under rtl
package mbe_pkg;

   localparam int FRAC_BITS = 28;
   localparam int CW        = FRAC_BITS + 17;   // width of c: 32-bit min plus 12x31 product
   localparam int ZW        = CW + 1;           // width of z after one add
   localparam int NW        = FRAC_BITS + 2;    // z inside the bound fits here
   localparam int PW        = 2 * NW;           // square width
   localparam int DVW       = 24;               // divider dividend width
   localparam int MW        = 16;               // max_iter width
   localparam int COLW      = 24;

   localparam longint ZBOUND  = 64'sd2 <<< FRAC_BITS;
   localparam longint NZBOUND = -ZBOUND;
   localparam longint FOUR_SQ = 64'sd1 <<< (2 * FRAC_BITS + 2);

   typedef enum logic [2:0] {
      REG_X_MIN          = 3'd0,
      REG_Y_MIN          = 3'd1,
      REG_X_STEP         = 3'd2,
      REG_Y_STEP         = 3'd3,
      REG_MAX_ITER       = 3'd4,
      REG_PALETTE_COUNT  = 3'd5,
      REG_PALETTE_FIRST  = 3'd6,
      REG_PALETTE_SECOND = 3'd7
   } mbe_reg_type;

   typedef struct packed {
      logic signed [31:0] x_min;
      logic signed [31:0] y_min;
      logic [30:0]        x_step;
      logic [30:0]        y_step;
      logic [MW-1:0]      max_iter;
      logic [2:0]         palette_count;
      logic [47:0]        palette_first;
      logic [47:0]        palette_second;
   } mbe_cfg_type;

   typedef struct packed {
      logic       start;
      logic       square;
      logic       step;
      logic       div_go;
      logic       div_chan;
      logic       latch_idx;
      logic       blend_mul;
      logic       latch_chan;
      logic [1:0] chan;
   } mbe_cmd_type;

   typedef struct packed {
      logic mi_zero;
      logic esc_now;
      logic fixed;
      logic last;
      logic div_done;
   } mbe_stat_type;

   // palette count saturated to 2 .. 4
   function automatic logic [2:0] usable_count(input logic [2:0] n);
      logic [2:0] r;
      r = n;
      if (n < 3'd2) r = 3'd2;
      if (n > 3'd4) r = 3'd4;
      return r;
   endfunction

   function automatic logic [COLW-1:0] colour_at(input mbe_cfg_type cfg, input logic [1:0] k);
      logic [47:0] word;
      word = k[1] ? cfg.palette_second : cfg.palette_first;
      return k[0] ? word[47:24] : word[23:0];
   endfunction

endpackage

[rtl/mbe_div.sv]
// mbe_div: restoring divider, one quotient bit per cycle
// depends on mbe_pkg
module mbe_div import mbe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  logic [DVW-1:0] dividend,
   input  logic [MW-1:0]  divisor,
   output logic [DVW-1:0] quot,
   output logic [MW-1:0]  rem,
   output logic           done
);

   logic [DVW-1:0] q_ff;
   logic [MW-1:0]  r_ff;
   logic [4:0]     cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [MW+1:0]  trial;

   assign trial = {1'b0, r_ff, q_ff[DVW-1]} - {2'b00, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(DVW - 1);
         end else if (busy_ff) begin
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         q_ff <= dividend;
         r_ff <= '0;
      end else if (busy_ff) begin
         if (!trial[MW+1]) begin
            r_ff <= trial[MW-1:0];
            q_ff <= {q_ff[DVW-2:0], 1'b1};
         end else begin
            r_ff <= {r_ff[MW-2:0], q_ff[DVW-1]};
            q_ff <= {q_ff[DVW-2:0], 1'b0};
         end
      end
   end

   assign quot = q_ff;
   assign rem  = r_ff;
   assign done = done_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule

[rtl/mbe_datapath.sv]
// mbe_datapath: c setup, z iteration, escape test and palette blend
// depends on mbe_pkg and mbe_div
module mbe_datapath import mbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mbe_cfg_type       cfg,
   input  mbe_cmd_type       cmd,
   input  logic [11:0]       req_col,
   input  logic [11:0]       req_row,
   output mbe_stat_type      stat,
   output logic [COLW-1:0]   colour,
   output logic [MW-1:0]     iterations,
   output logic              escaped
);

   logic signed [CW-1:0] cr_ff, ci_ff, cr_in, ci_in;
   logic signed [ZW-1:0] zr_ff, zi_ff, nr, ni;
   logic signed [NW-1:0] zrn, zin;
   logic signed [PW-1:0] rr_ff, ii_ff, ri_ff;
   logic                 big_ff;
   logic signed [PW:0]   diff, sum;
   logic [42:0]          xprod, yprod;
   logic [MW-1:0]        iter_ff;
   logic                 esc_ff;
   logic [COLW-1:0]      col_ff;
   logic [1:0]           idx_ff;
   logic [MW-1:0]        r_ff;
   logic [23:0]          am_ff [3];
   logic signed [25:0]   dr_ff [3];
   logic [2:0]           n;
   logic [17:0]          p;
   logic signed [25:0]   num;
   logic [DVW-1:0]       div_dvd, div_q;
   logic [MW-1:0]        div_r;
   logic                 div_done;
   logic [COLW-1:0]      ca, cb;

   assign xprod = req_col * cfg.x_step;
   assign yprod = req_row * cfg.y_step;
   assign cr_in = CW'(cfg.x_min) + $signed({{(CW-43){1'b0}}, xprod});
   assign ci_in = CW'(cfg.y_min) + $signed({{(CW-43){1'b0}}, yprod});

   assign zrn  = zr_ff[NW-1:0];
   assign zin  = zi_ff[NW-1:0];
   assign diff = {rr_ff[PW-1], rr_ff} - {ii_ff[PW-1], ii_ff};
   assign sum  = {rr_ff[PW-1], rr_ff} + {ii_ff[PW-1], ii_ff};
   // floor shift is the upper slice; 2*re*im drops one bit less
   assign nr   = ZW'($signed(diff[PW:FRAC_BITS])) + ZW'(cr_ff);
   assign ni   = ZW'($signed(ri_ff[PW-1:FRAC_BITS-1])) + ZW'(ci_ff);

   assign n     = usable_count(cfg.palette_count);
   assign p     = 18'(iter_ff) * {15'd0, n - 3'd1};
   assign ca    = colour_at(cfg, idx_ff);
   assign cb    = colour_at(cfg, idx_ff + 2'd1);
   assign num   = $signed({2'b00, am_ff[cmd.chan]}) + dr_ff[cmd.chan];
   assign div_dvd = cmd.div_chan ? num[DVW-1:0] : DVW'(p);

   assign stat.mi_zero  = (cfg.max_iter == '0);
   assign stat.esc_now  = big_ff || (sum >= (PW+1)'(FOUR_SQ));
   assign stat.fixed    = (nr == zr_ff) && (ni == zi_ff);
   assign stat.last     = ({1'b0, iter_ff} + 17'd1) == {1'b0, cfg.max_iter};
   assign stat.div_done = div_done;

   mbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dvd),
      .divisor  (cfg.max_iter),
      .quot     (div_q),
      .rem      (div_r),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cr_ff   <= cr_in;
         ci_ff   <= ci_in;
         zr_ff   <= '0;
         zi_ff   <= '0;
         iter_ff <= '0;
         esc_ff  <= 1'b0;
         col_ff  <= colour_at(cfg, 2'(n - 3'd1));
      end
      if (cmd.square) begin
         big_ff <= (zr_ff >= ZW'(ZBOUND)) || (zr_ff <= ZW'(NZBOUND)) ||
                   (zi_ff >= ZW'(ZBOUND)) || (zi_ff <= ZW'(NZBOUND));
         rr_ff  <= zrn * zrn;
         ii_ff  <= zin * zin;
         ri_ff  <= zrn * zin;
      end
      if (cmd.step) begin
         if (stat.esc_now) begin
            esc_ff <= 1'b1;
         end else begin
            zr_ff   <= nr;
            zi_ff   <= ni;
            iter_ff <= iter_ff + 16'd1;
         end
      end
      if (cmd.latch_idx) begin
         idx_ff <= div_q[1:0];
         r_ff   <= div_r;
      end
      if (cmd.blend_mul) begin
         for (int c = 0; c < 3; c++) begin
            am_ff[c] <= ca[8*c +: 8] * cfg.max_iter;
            dr_ff[c] <= ($signed({1'b0, cb[8*c +: 8]}) - $signed({1'b0, ca[8*c +: 8]})) *
                        $signed({1'b0, r_ff});
         end
      end
      if (cmd.latch_chan) begin
         col_ff[8*cmd.chan +: 8] <= div_q[7:0];
      end
   end

   assign colour     = col_ff;
   assign iterations = esc_ff ? iter_ff : cfg.max_iter;
   assign escaped    = esc_ff;

   a_z_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (zr_ff == '0) && (zi_ff == '0) && !esc_ff)
      else $error("z not cleared at pixel start");

endmodule

[rtl/mbe_ctrl.sv]
// mbe_ctrl: sequencer for iteration, index divide and per-channel blend divides
// depends on mbe_pkg
module mbe_ctrl import mbe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  mbe_stat_type stat,
   input  logic         out_free,
   output logic         load_rsp,
   output mbe_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_STEP, ST_IDX, ST_IDX_WAIT, ST_MUL, ST_CH, ST_CH_WAIT, ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] chan_ff, chan_in;

   always_comb begin
      state_in   = state_ff;
      chan_in    = chan_ff;
      cmd        = '0;
      cmd.chan   = chan_ff;
      load_rsp   = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = stat.mi_zero ? ST_FINISH : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (stat.esc_now)                 state_in = ST_IDX;
            else if (stat.fixed || stat.last) state_in = ST_FINISH;
            else                              state_in = ST_SQUARE;
         end
         ST_IDX: begin
            cmd.div_go = 1'b1;
            state_in   = ST_IDX_WAIT;
         end
         ST_IDX_WAIT: begin
            if (stat.div_done) begin
               cmd.latch_idx = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.blend_mul = 1'b1;
            chan_in       = 2'd0;
            state_in      = ST_CH;
         end
         ST_CH: begin
            cmd.div_go   = 1'b1;
            cmd.div_chan = 1'b1;
            state_in     = ST_CH_WAIT;
         end
         ST_CH_WAIT: begin
            if (stat.div_done) begin
               cmd.latch_chan = 1'b1;
               if (chan_ff == 2'd2) begin
                  state_in = ST_FINISH;
               end else begin
                  chan_in  = chan_ff + 2'd1;
                  state_in = ST_CH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

   a_esc_to_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && stat.esc_now) |=> state_ff == ST_IDX)
      else $error("escape did not start interpolation");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_chan |-> chan_ff != 2'd3)
      else $error("blend channel out of range");

endmodule

[rtl/mandelbrot_escape_time_colour.sv]
// mandelbrot_escape_time_colour: top level, config registers and result register
// depends on mbe_pkg, mbe_ctrl, mbe_datapath
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: col[11:0], row[23:12]
//  rsp     | out | rsp_tvalid/tready    | tdata: red, green, blue, iterations, escaped
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// each step runs a square state, then an add and test state; a pixel also has an accept and a finish state
// an escape then runs the index divide, the blend multiply and one divide for each colour channel
// the next beat is taken while the previous result waits in the output register
// a finished pixel holds in its last state while that register is full and rsp_tready is low
// reset is synchronous and clears control state and config registers to defaults
module mandelbrot_escape_time_colour import mbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // col[11:0], row[23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // red[7:0], green[15:8], blue[23:16], iterations[39:24],
                                     // escaped[40], zero[47:41]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   mbe_cfg_type     cfg_ff;
   mbe_cmd_type     cmd;
   mbe_stat_type    stat;
   logic            load_rsp;
   logic            out_free;
   logic [COLW-1:0] colour;
   logic [MW-1:0]   iterations;
   logic            escaped;
   logic            rsp_tvalid_ff;
   logic [47:0]     rsp_tdata_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_min          <= -32'sd536870912;
         cfg_ff.y_min          <= -32'sd268435456;
         cfg_ff.x_step         <= 31'd1048576;
         cfg_ff.y_step         <= 31'd1048576;
         cfg_ff.max_iter       <= 16'd256;
         cfg_ff.palette_count  <= 3'd2;
         cfg_ff.palette_first  <= 48'hFF_FFFF;
         cfg_ff.palette_second <= '0;
      end else if (csr_valid) begin
         case (mbe_reg_type'(csr_index))
            REG_X_MIN:          cfg_ff.x_min          <= $signed(csr_data[31:0]);
            REG_Y_MIN:          cfg_ff.y_min          <= $signed(csr_data[31:0]);
            REG_X_STEP:         cfg_ff.x_step         <= csr_data[30:0];
            REG_Y_STEP:         cfg_ff.y_step         <= csr_data[30:0];
            REG_MAX_ITER:       cfg_ff.max_iter       <= csr_data[15:0];
            REG_PALETTE_COUNT:  cfg_ff.palette_count  <= csr_data[2:0];
            REG_PALETTE_FIRST:  cfg_ff.palette_first  <= csr_data;
            REG_PALETTE_SECOND: cfg_ff.palette_second <= csr_data;
            default: ;
         endcase
      end
   end

   mbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .out_free   (out_free),
      .load_rsp   (load_rsp),
      .cmd        (cmd)
   );

   mbe_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .req_col    (req_tdata[11:0]),
      .req_row    (req_tdata[23:12]),
      .stat       (stat),
      .colour     (colour),
      .iterations (iterations),
      .escaped    (escaped)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_tdata_ff <= {7'd0, escaped, iterations, colour[7:0], colour[15:8], colour[23:16]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten while holding a beat");

endmodule
